// ===== rtl/core/dghf_pkg.sv =====
// shared types and constants for the depth guided row hole fill block
package dghf_pkg;

    localparam int PIX_W = 8;
    localparam int RUN_W = 11;

    // one pixel item
    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_b;
        logic [PIX_W-1:0] chroma_r;
        logic [PIX_W-1:0] depth;
        logic             row_end;
    } t_pix;

    // one run-length item
    typedef struct packed {
        logic [RUN_W-1:0] run_length;
        logic [PIX_W-1:0] out_luma;
        logic [PIX_W-1:0] out_chroma_b;
        logic [PIX_W-1:0] out_chroma_r;
        logic             was_filled;
        logic             ends_row;
        logic             last_of_item;
    } t_run;

    // most recent valid pixel of the current row
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_b;
        logic [PIX_W-1:0] chroma_r;
        logic [PIX_W-1:0] depth;
    } t_left;

    localparam t_left LEFT_CLEAR = '0;

endpackage

// ===== rtl/core/dghf_fill.sv =====
// fill decision: runs produced by one pixel and the next row state
module dghf_fill #(
    parameter int MAX_ROW_WIDTH = 1024,
    parameter int HCW           = 11
) (
    input  dghf_pkg::t_pix  i_pix,
    input  dghf_pkg::t_left i_left,
    input  logic [HCW-1:0]  i_hole_cnt,
    output logic [1:0]      o_num_runs,
    output dghf_pkg::t_run  o_run0,
    output dghf_pkg::t_run  o_run1,
    output dghf_pkg::t_left o_left,
    output logic [HCW-1:0]  o_hole_cnt
);
    import dghf_pkg::*;

    logic           hole;
    logic [HCW-1:0] hole_cnt_inc;
    logic           take_left;
    t_run           pass_run;

    // hole detection and saturating count
    assign hole         = (i_pix.luma == '0);
    assign hole_cnt_inc = (i_hole_cnt < HCW'(MAX_ROW_WIDTH)) ? i_hole_cnt + HCW'(1)
                                                             : i_hole_cnt;
    // left neighbor wins ties on depth
    assign take_left    = i_left.valid && (i_left.depth <= i_pix.depth);

    // the pixel's own pass-through run
    always_comb begin
        pass_run.run_length   = RUN_W'(1);
        pass_run.out_luma     = i_pix.luma;
        pass_run.out_chroma_b = i_pix.chroma_b;
        pass_run.out_chroma_r = i_pix.chroma_r;
        pass_run.was_filled   = 1'b0;
        pass_run.ends_row     = i_pix.row_end;
        pass_run.last_of_item = 1'b1;
    end

    // runs caused by this pixel
    always_comb begin
        o_num_runs = 2'd0;
        o_run0     = pass_run;
        o_run1     = pass_run;
        if (hole) begin
            // left colors are zero when no valid pixel was seen in this row
            o_run0.run_length   = RUN_W'(hole_cnt_inc);
            o_run0.out_luma     = i_left.luma;
            o_run0.out_chroma_b = i_left.chroma_b;
            o_run0.out_chroma_r = i_left.chroma_r;
            o_run0.was_filled   = i_left.valid;
            o_run0.ends_row     = 1'b1;
            o_run0.last_of_item = 1'b1;
            o_num_runs          = i_pix.row_end ? 2'd1 : 2'd0;
        end else if (i_hole_cnt != '0) begin
            o_run0.run_length   = RUN_W'(i_hole_cnt);
            o_run0.out_luma     = take_left ? i_left.luma     : i_pix.luma;
            o_run0.out_chroma_b = take_left ? i_left.chroma_b : i_pix.chroma_b;
            o_run0.out_chroma_r = take_left ? i_left.chroma_r : i_pix.chroma_r;
            o_run0.was_filled   = 1'b1;
            o_run0.ends_row     = 1'b0;
            o_run0.last_of_item = 1'b0;
            o_num_runs          = 2'd2;
        end else begin
            o_num_runs = 2'd1;
        end
    end

    // next row state
    always_comb begin
        o_left     = i_left;
        o_hole_cnt = i_hole_cnt;
        if (i_pix.row_end) begin
            o_left     = LEFT_CLEAR;
            o_hole_cnt = '0;
        end else if (hole) begin
            o_hole_cnt = hole_cnt_inc;
        end else begin
            o_left.valid    = 1'b1;
            o_left.luma     = i_pix.luma;
            o_left.chroma_b = i_pix.chroma_b;
            o_left.chroma_r = i_pix.chroma_r;
            o_left.depth    = i_pix.depth;
            o_hole_cnt      = '0;
        end
    end

endmodule

// ===== rtl/core/depth_guided_row_hole_fill.sv =====
// top level of the depth guided row hole fill block
//
//  channel | direction | handshake            | payload
//  pixel   | in        | i_valid / o_stall    | i_pix (t_pix)
//  run     | out       | o_valid / i_stall    | o_run (t_run)
//
// a pixel sits in the input register, then its runs go to a
// two-entry result buffer; the output shows the buffer head
// one pixel per cycle while each pixel yields at most one run and i_stall is
// low; a pixel that closes a hole run yields two runs and stalls the input.
// synchronous active-low reset clears row state, valids and the buffer count
// the input register is released only when the result buffer can take two runs
module depth_guided_row_hole_fill #(
    parameter int MAX_ROW_WIDTH = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  dghf_pkg::t_pix i_pix,
    output logic           o_valid,
    input  logic           i_stall,
    output dghf_pkg::t_run o_run
);
    import dghf_pkg::*;

    localparam int HCW = $clog2(MAX_ROW_WIDTH + 1);

    logic           r_in_vld, n_in_vld;
    t_pix           r_in;
    t_left          r_left, n_left;
    logic [HCW-1:0] r_hole_cnt, n_hole_cnt;
    t_run           r_q [2];
    t_run           n_q [2];
    logic [1:0]     r_cnt, n_cnt;

    logic           pop;
    logic           consume;
    logic           accept;
    logic [1:0]     num_runs;
    t_run           run0, run1;

    // fill decision for the registered pixel
    dghf_fill #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
        .HCW           (HCW)
    ) u_fill (
        .i_pix      (r_in),
        .i_left     (r_left),
        .i_hole_cnt (r_hole_cnt),
        .o_num_runs (num_runs),
        .o_run0     (run0),
        .o_run1     (run1),
        .o_left     (n_left),
        .o_hole_cnt (n_hole_cnt)
    );

    // handshakes
    assign o_valid = (r_cnt != 2'd0);
    assign o_run   = r_q[0];
    assign pop     = o_valid && !i_stall;
    assign consume = r_in_vld && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop));
    assign o_stall = r_in_vld && !consume;
    assign accept  = i_valid && !o_stall;
    assign n_in_vld = accept || (r_in_vld && !consume);

    // result buffer next value
    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (consume) begin
            n_q[0] = run0;
            n_q[1] = run1;
            n_cnt  = num_runs;
        end else if (pop) begin
            n_q[0] = r_q[1];
            n_cnt  = r_cnt - 2'd1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_cnt      <= 2'd0;
            r_left     <= LEFT_CLEAR;
            r_hole_cnt <= '0;
        end else begin
            r_in_vld <= n_in_vld;
            r_cnt    <= n_cnt;
            if (consume) begin
                r_left     <= n_left;
                r_hole_cnt <= n_hole_cnt;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_pix;
        end
        r_q <= n_q;
    end

endmodule
